// ===== design/mwpo_pkg.sv =====
`default_nettype none

package mwpo_pkg;

    // Field and register widths
    localparam int STEP_W   = 32;
    localparam int SAMPLE_W = 16;
    localparam int COUNT_W  = 7;
    localparam int TIDX_W   = 10;
    localparam int MODE_W   = 3;
    localparam int OP_W     = 4;
    localparam int PSTEP_W  = 3;

    // Parameter defaults
    localparam int TABLE_DEPTH_DEF    = 1024;
    localparam int SINE_ROM_DEPTH_DEF = 1024;
    localparam int MAX_RUN_DEF        = 64;

    // Wave modes
    localparam logic [MODE_W-1:0] MODE_SINE   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SQUARE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SAW    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TRI    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_NOISE  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_TABLE  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SILENT = 3'd6;

    // Sine polynomial coefficients, Q30
    localparam logic [31:0] SIN_C1 = 32'd1686629713;
    localparam logic [31:0] SIN_C3 = 32'd693598650;
    localparam logic [31:0] SIN_C5 = 32'd85569300;
    localparam logic [31:0] SIN_C7 = 32'd5026990;
    localparam logic [31:0] SIN_C9 = 32'd172271;

    localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

    // Polynomial step codes
    localparam logic [PSTEP_W-1:0] PS_SQUARE = 3'd0;
    localparam logic [PSTEP_W-1:0] PS_C9     = 3'd1;
    localparam logic [PSTEP_W-1:0] PS_C5     = 3'd2;
    localparam logic [PSTEP_W-1:0] PS_C3     = 3'd3;
    localparam logic [PSTEP_W-1:0] PS_C1     = 3'd4;
    localparam logic [PSTEP_W-1:0] PS_T      = 3'd5;
    localparam logic [PSTEP_W-1:0] PS_SCALE  = 3'd6;

    // Datapath commands
    localparam logic [OP_W-1:0] OP_NONE          = 4'd0;
    localparam logic [OP_W-1:0] OP_ACCEPT        = 4'd1;
    localparam logic [OP_W-1:0] OP_DIV_DELTA     = 4'd2;
    localparam logic [OP_W-1:0] OP_DELTA_TAKE    = 4'd3;
    localparam logic [OP_W-1:0] OP_FORM_SIMPLE   = 4'd4;
    localparam logic [OP_W-1:0] OP_MUL_IDX_SINE  = 4'd5;
    localparam logic [OP_W-1:0] OP_MUL_IDX_TBL   = 4'd6;
    localparam logic [OP_W-1:0] OP_SINE_U_DIRECT = 4'd7;
    localparam logic [OP_W-1:0] OP_DIV_SINE      = 4'd8;
    localparam logic [OP_W-1:0] OP_SINE_U_DIV    = 4'd9;
    localparam logic [OP_W-1:0] OP_TBL_READ      = 4'd10;
    localparam logic [OP_W-1:0] OP_TBL_TAKE      = 4'd11;
    localparam logic [OP_W-1:0] OP_POLY_MUL      = 4'd12;
    localparam logic [OP_W-1:0] OP_POLY_TAKE     = 4'd13;
    localparam logic [OP_W-1:0] OP_EMIT          = 4'd14;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [PSTEP_W-1:0] pstep;
        logic               last;
        logic [COUNT_W-1:0] run_len;
    } mwpo_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              div_done;
        logic              out_free;
    } mwpo_stat_t;

endpackage

`default_nettype wire

// ===== design/mwpo_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module mwpo_div
    import mwpo_pkg::*;
#(
    parameter int DVD_W = 42,
    parameter int DVS_W = 11
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic                  done,
    output logic      [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   rem_sub;
    logic             ge;

    always_comb begin
        rem_sh   = {rem_reg, quo_reg[DVD_W-1]};
        rem_sub  = rem_sh - {1'b0, dvs_reg};
        ge       = (rem_sh >= {1'b0, dvs_reg});
        rem_next = ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        quo_next = {quo_reg[DVD_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DVD_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== design/mwpo_dpath.sv =====
`default_nettype none

module mwpo_dpath
    import mwpo_pkg::*;
#(
    parameter int TABLE_DEPTH    = TABLE_DEPTH_DEF,
    parameter int SINE_ROM_DEPTH = SINE_ROM_DEPTH_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_we,
    input  wire logic [MODE_W-1:0]          cfg_wdata,
    input  wire logic                       s_req_type,
    input  wire logic [STEP_W-1:0]          s_start_step,
    input  wire logic [STEP_W-1:0]          s_end_step,
    input  wire logic [TIDX_W-1:0]          s_table_index,
    input  wire logic signed [SAMPLE_W-1:0] s_table_value,
    input  wire mwpo_cmd_t                  cmd,
    output mwpo_stat_t                      stat,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic signed [SAMPLE_W-1:0]      m_sample,
    output logic                            m_last
);

    localparam int TBL_AW = $clog2(TABLE_DEPTH);
    localparam int SIDX_W = $clog2(SINE_ROM_DEPTH);
    localparam int DVD_W  = STEP_W + SIDX_W;
    localparam int DSW    = $clog2(SINE_ROM_DEPTH + 1);
    localparam int DVS_W  = (DSW > COUNT_W) ? DSW : COUNT_W;
    localparam logic [31:0] TBL_CONST  = 32'(TABLE_DEPTH);
    localparam logic [31:0] SINE_CONST = 32'(SINE_ROM_DEPTH);

    logic [MODE_W-1:0]          mode_reg;
    logic [STEP_W-1:0]          phase_reg;
    logic [31:0]                lfsr_reg;
    logic [STEP_W-1:0]          start_reg;
    logic [STEP_W-1:0]          end_reg;
    logic [STEP_W-1:0]          step_reg;
    logic [STEP_W-1:0]          delta_reg;
    logic                       dneg_reg;
    logic [63:0]                prod_reg;
    logic [31:0]                t_reg;
    logic [31:0]                t2_reg;
    logic [31:0]                acc_reg;
    logic [1:0]                 quad_reg;
    logic [SAMPLE_W-1:0]        res_reg;
    logic signed [SAMPLE_W-1:0] tbl_q_reg;
    logic                       m_valid_reg;
    logic signed [SAMPLE_W-1:0] m_sample_reg;
    logic                       m_last_reg;

    logic signed [SAMPLE_W-1:0] wave_mem [0:TABLE_DEPTH-1];

    // Divider hookup
    logic              div_start;
    logic [DVD_W-1:0]  div_dividend;
    logic [DVS_W-1:0]  div_divisor;
    logic              div_done;
    logic [DVD_W-1:0]  div_q;
    logic [STEP_W:0]   diff;
    logic [STEP_W:0]   mag;

    assign diff = {1'b0, end_reg} - {1'b0, start_reg};
    assign mag  = diff[STEP_W] ? ((STEP_W+1)'(0) - diff) : diff;

    always_comb begin
        div_start = (cmd.op == OP_DIV_DELTA) || (cmd.op == OP_DIV_SINE);
        if (cmd.op == OP_DIV_DELTA) begin
            div_dividend = {{SIDX_W{1'b0}}, mag[STEP_W-1:0]};
            div_divisor  = DVS_W'(cmd.run_len);
        end else begin
            div_dividend = {prod_reg[32 +: SIDX_W], 32'd0};
            div_divisor  = DVS_W'(SINE_ROM_DEPTH);
        end
    end

    mwpo_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // Shared multiplier operand select
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;

    always_comb begin
        mul_a = phase_reg;
        mul_b = SINE_CONST;
        if (cmd.op == OP_MUL_IDX_TBL) begin
            mul_b = TBL_CONST;
        end else if (cmd.op == OP_POLY_MUL) begin
            unique case (cmd.pstep)
                PS_SQUARE: begin
                    mul_a = t_reg;
                    mul_b = t_reg;
                end
                PS_C9: begin
                    mul_a = SIN_C9;
                    mul_b = t2_reg;
                end
                PS_C5, PS_C3, PS_C1: begin
                    mul_a = acc_reg;
                    mul_b = t2_reg;
                end
                PS_T: begin
                    mul_a = t_reg;
                    mul_b = acc_reg;
                end
                default: begin
                    mul_a = acc_reg;
                    mul_b = 32'd32767;
                end
            endcase
        end
        mul_p = mul_a * mul_b;
    end

    // Sine fraction of a turn, then quadrant fold
    logic [31:0] u_val;
    logic [31:0] prod_sh;
    logic [31:0] coef;
    logic [47:0] rnd;
    logic [17:0] v18;
    logic [15:0] vcap;

    always_comb begin
        if (cmd.op == OP_SINE_U_DIV) begin
            u_val = div_q[31:0];
        end else begin
            u_val = {prod_reg[32 +: SIDX_W], {(32-SIDX_W){1'b0}}};
        end
        prod_sh = prod_reg[61:30];
        unique case (cmd.pstep)
            PS_C9:   coef = SIN_C7;
            PS_C5:   coef = SIN_C5;
            PS_C3:   coef = SIN_C3;
            PS_C1:   coef = SIN_C1;
            default: coef = '0;
        endcase
        rnd  = prod_reg[47:0] + 48'h0000_2000_0000;
        v18  = rnd[47:30];
        vcap = (v18 > 18'd32767) ? 16'd32767 : v18[15:0];
    end

    // Simple waveforms
    logic [31:0]         lfsr_next;
    logic [SAMPLE_W-1:0] simple_val;
    logic                adv;

    always_comb begin
        lfsr_next = {1'b0, lfsr_reg[31:1]};
        if (lfsr_reg[0]) begin
            lfsr_next = lfsr_next ^ LFSR_TAPS;
        end
        unique case (mode_reg)
            MODE_SQUARE: simple_val = phase_reg[31] ? 16'h8000 : 16'h7fff;
            MODE_SAW:    simple_val = {~phase_reg[31], phase_reg[30:16]};
            MODE_TRI: begin
                if (!phase_reg[31]) begin
                    simple_val = {~phase_reg[30], phase_reg[29:15]};
                end else if (phase_reg[30:15] == 16'd0) begin
                    simple_val = 16'h7fff;
                end else begin
                    simple_val = 16'h8000 - phase_reg[30:15];
                end
            end
            MODE_NOISE:  simple_val = {~lfsr_next[15], lfsr_next[14:0]};
            default:     simple_val = '0;
        endcase
        adv = (mode_reg == MODE_SINE) || (mode_reg == MODE_SQUARE) ||
              (mode_reg == MODE_SAW) || (mode_reg == MODE_TRI) ||
              (mode_reg == MODE_TABLE);
    end

    // Control-side state: mode, phase, noise, result slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_SINE;
            phase_reg   <= '0;
            lfsr_reg    <= 32'd1;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                mode_reg  <= cfg_wdata;
                phase_reg <= '0;
            end else if (cmd.op == OP_EMIT && adv) begin
                phase_reg <= phase_reg + step_reg;
            end
            if (cmd.op == OP_FORM_SIMPLE && mode_reg == MODE_NOISE) begin
                lfsr_reg <= lfsr_next;
            end
            if (cmd.op == OP_EMIT) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_ACCEPT: begin
                start_reg <= s_start_step;
                end_reg   <= s_end_step;
            end
            OP_DIV_DELTA: dneg_reg <= diff[STEP_W];
            OP_DELTA_TAKE: begin
                delta_reg <= dneg_reg ? (STEP_W'(0) - div_q[STEP_W-1:0])
                                      : div_q[STEP_W-1:0];
                step_reg  <= start_reg;
            end
            OP_FORM_SIMPLE: res_reg <= simple_val;
            OP_MUL_IDX_SINE, OP_MUL_IDX_TBL, OP_POLY_MUL: prod_reg <= mul_p;
            OP_SINE_U_DIRECT, OP_SINE_U_DIV: begin
                quad_reg <= u_val[31:30];
                t_reg    <= u_val[30] ? (32'h4000_0000 - {2'b00, u_val[29:0]})
                                      : {2'b00, u_val[29:0]};
            end
            OP_TBL_TAKE: res_reg <= tbl_q_reg;
            OP_POLY_TAKE: begin
                unique case (cmd.pstep)
                    PS_SQUARE:                 t2_reg  <= prod_sh;
                    PS_C9, PS_C5, PS_C3, PS_C1: acc_reg <= coef - prod_sh;
                    PS_T:                      acc_reg <= prod_sh;
                    default: res_reg <= quad_reg[1] ? (16'd0 - vcap) : vcap;
                endcase
            end
            OP_EMIT: begin
                step_reg     <= step_reg + delta_reg;
                m_sample_reg <= res_reg;
                m_last_reg   <= cmd.last;
            end
            default: ;
        endcase
    end

    // Wave table
    logic [31:0] widx;
    assign widx = {{(32-TIDX_W){1'b0}}, s_table_index};

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_ACCEPT && s_req_type && widx < TBL_CONST) begin
            wave_mem[widx[TBL_AW-1:0]] <= s_table_value;
        end
        if (cmd.op == OP_TBL_READ) begin
            tbl_q_reg <= wave_mem[prod_reg[32 +: TBL_AW]];
        end
    end

    assign stat.mode     = mode_reg;
    assign stat.div_done = div_done;
    assign stat.out_free = !m_valid_reg || m_ready;

    assign m_valid  = m_valid_reg;
    assign m_sample = m_sample_reg;
    assign m_last   = m_last_reg;

    a_lfsr_live: assert property (@(posedge aclk) disable iff (!aresetn)
        lfsr_reg != 32'd0)
        else $error("noise register fell into the all-zero state");

    a_hold_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_EMIT && !cfg_we &&
         (mode_reg == MODE_NOISE || mode_reg == MODE_SILENT)) |=> $stable(phase_reg))
        else $error("phase moved in a mode that must hold it");

    a_div_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_DIV_DELTA) |=> !div_done)
        else $error("divider reported done right after a start");

endmodule

`default_nettype wire

// ===== design/mwpo_ctrl.sv =====
`default_nettype none

module mwpo_ctrl
    import mwpo_pkg::*;
#(
    parameter int MAX_RUN        = MAX_RUN_DEF,
    parameter int SINE_ROM_DEPTH = SINE_ROM_DEPTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_req_type,
    input  wire logic [COUNT_W-1:0] s_count,
    input  wire mwpo_stat_t         stat,
    output mwpo_cmd_t               cmd
);

    localparam bit SINE_POW2 = ((SINE_ROM_DEPTH & (SINE_ROM_DEPTH - 1)) == 0);
    localparam logic [COUNT_W-1:0] RUN_MAX = COUNT_W'(MAX_RUN);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DDIV  = 4'd1;
    localparam logic [3:0] ST_DWAIT = 4'd2;
    localparam logic [3:0] ST_FORM  = 4'd3;
    localparam logic [3:0] ST_IUSE  = 4'd4;
    localparam logic [3:0] ST_SWAIT = 4'd5;
    localparam logic [3:0] ST_TREAD = 4'd6;
    localparam logic [3:0] ST_TTAKE = 4'd7;
    localparam logic [3:0] ST_PMUL  = 4'd8;
    localparam logic [3:0] ST_PTAKE = 4'd9;
    localparam logic [3:0] ST_EMIT  = 4'd10;

    logic [3:0]         state_reg, state_next;
    logic [COUNT_W-1:0] n_reg, n_next;
    logic [COUNT_W-1:0] k_reg, k_next;
    logic [PSTEP_W-1:0] ps_reg, ps_next;
    logic [COUNT_W-1:0] run_cap;
    logic               is_last;

    assign run_cap = (s_count > RUN_MAX) ? RUN_MAX : s_count;
    assign is_last = ((k_reg + COUNT_W'(1)) == n_reg);
    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next  = state_reg;
        n_next      = n_reg;
        k_next      = k_reg;
        ps_next     = ps_reg;
        cmd.op      = OP_NONE;
        cmd.pstep   = ps_reg;
        cmd.last    = is_last;
        cmd.run_len = n_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.op = OP_ACCEPT;
                    if (!s_req_type && s_count != '0) begin
                        n_next     = run_cap;
                        k_next     = '0;
                        state_next = ST_DDIV;
                    end
                end
            end
            ST_DDIV: begin
                cmd.op     = OP_DIV_DELTA;
                state_next = ST_DWAIT;
            end
            ST_DWAIT: begin
                if (stat.div_done) begin
                    cmd.op     = OP_DELTA_TAKE;
                    state_next = ST_FORM;
                end
            end
            ST_FORM: begin
                if (stat.mode == MODE_SINE) begin
                    cmd.op     = OP_MUL_IDX_SINE;
                    state_next = ST_IUSE;
                end else if (stat.mode == MODE_TABLE) begin
                    cmd.op     = OP_MUL_IDX_TBL;
                    state_next = ST_TREAD;
                end else begin
                    cmd.op     = OP_FORM_SIMPLE;
                    state_next = ST_EMIT;
                end
            end
            ST_IUSE: begin
                ps_next = PS_SQUARE;
                if (SINE_POW2) begin
                    cmd.op     = OP_SINE_U_DIRECT;
                    state_next = ST_PMUL;
                end else begin
                    cmd.op     = OP_DIV_SINE;
                    state_next = ST_SWAIT;
                end
            end
            ST_SWAIT: begin
                if (stat.div_done) begin
                    cmd.op     = OP_SINE_U_DIV;
                    state_next = ST_PMUL;
                end
            end
            ST_TREAD: begin
                cmd.op     = OP_TBL_READ;
                state_next = ST_TTAKE;
            end
            ST_TTAKE: begin
                cmd.op     = OP_TBL_TAKE;
                state_next = ST_EMIT;
            end
            ST_PMUL: begin
                cmd.op     = OP_POLY_MUL;
                state_next = ST_PTAKE;
            end
            ST_PTAKE: begin
                cmd.op = OP_POLY_TAKE;
                if (ps_reg == PS_SCALE) begin
                    state_next = ST_EMIT;
                end else begin
                    ps_next    = ps_reg + PSTEP_W'(1);
                    state_next = ST_PMUL;
                end
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.op = OP_EMIT;
                    if (is_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        k_next     = k_reg + COUNT_W'(1);
                        state_next = ST_FORM;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            n_reg     <= '0;
            k_reg     <= '0;
            ps_reg    <= PS_SQUARE;
        end else begin
            state_reg <= state_next;
            n_reg     <= n_next;
            k_reg     <= k_next;
            ps_reg    <= ps_next;
        end
    end

    a_emit_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_EMIT) |-> stat.out_free)
        else $error("sample pushed into an occupied output slot");

    a_k_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (k_reg < n_reg))
        else $error("sample counter ran past the run length");

    a_run_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (n_reg != '0 && n_reg <= RUN_MAX))
        else $error("run length out of range during a run");

endmodule

`default_nettype wire

// ===== design/multi_wave_phase_oscillator_top.sv =====
`default_nettype none

// Multi-waveform DDS oscillator. A 32-bit phase accumulator advances once per
// output sample. A render request (s_req_type 0) produces min(s_count,
// MAX_RUN) Q1.15 samples on the m_ channel, m_last marking the final one,
// while the phase step ramps from s_start_step by (end - start) / run
// (signed, truncated toward zero) per sample; a count of zero produces
// nothing. A table request (s_req_type 1) writes one wave table entry and
// produces nothing; table mode must only read entries written before.
// cfg_we/cfg_wdata load the wave mode (0 sine, 1 square, 2 saw, 3 triangle,
// 4 noise, 5 table, 6 or 7 silent) and clear the phase; write it only while
// the block is idle. Noise and silent modes leave the phase untouched.
// One request is worked at a time; a table request is written in the same
// cycle it is accepted. A render request first runs the bit-serial divider
// that forms the ramp delta, then per sample: square, saw, triangle, noise
// and silent form the value directly, table takes a multiply plus a
// registered table read, and sine takes seven passes through the shared
// 32x32 multiplier evaluating the sine polynomial, plus one more divide per
// sine sample when the sine depth is not a power of two. Output
// back-pressure can stall the emission of any sample.
module multi_wave_phase_oscillator_top
    import mwpo_pkg::*;
#(
    parameter int TABLE_DEPTH    = TABLE_DEPTH_DEF,
    parameter int SINE_ROM_DEPTH = SINE_ROM_DEPTH_DEF,
    parameter int MAX_RUN        = MAX_RUN_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // Mode register write
    input  wire logic                       cfg_we,
    input  wire logic [MODE_W-1:0]          cfg_wdata,
    // Request channel
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic                       s_req_type,
    input  wire logic [STEP_W-1:0]          s_start_step,
    input  wire logic [STEP_W-1:0]          s_end_step,
    input  wire logic [COUNT_W-1:0]         s_count,
    input  wire logic [TIDX_W-1:0]          s_table_index,
    input  wire logic signed [SAMPLE_W-1:0] s_table_value,
    // Sample channel
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic signed [SAMPLE_W-1:0]      m_sample,
    output logic                            m_last
);

    mwpo_cmd_t  cmd;
    mwpo_stat_t stat;

    // Sequencer: accept, run the delta divide, walk each sample's steps.
    mwpo_ctrl #(
        .MAX_RUN        (MAX_RUN),
        .SINE_ROM_DEPTH (SINE_ROM_DEPTH)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .s_count    (s_count),
        .stat       (stat),
        .cmd        (cmd)
    );

    // Phase, noise, ramp, multiplier, divider, wave table and output slot.
    mwpo_dpath #(
        .TABLE_DEPTH    (TABLE_DEPTH),
        .SINE_ROM_DEPTH (SINE_ROM_DEPTH)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_req_type    (s_req_type),
        .s_start_step  (s_start_step),
        .s_end_step    (s_end_step),
        .s_table_index (s_table_index),
        .s_table_value (s_table_value),
        .cmd           (cmd),
        .stat          (stat),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sample      (m_sample),
        .m_last        (m_last)
    );

endmodule

`default_nettype wire
